// ----- sv/sdf_pkg.sv -----
// shared types, constants and helpers of the spring-damper feedback core
// no dependencies; imported by every module of the block
package sdf_pkg;

	localparam int DATA_W    = 32;
	localparam int STEP_W    = 24;
	localparam int STEP_FRAC = 24;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 66;
	localparam int CNT_W     = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [DATA_W-1:0] RST_GAIN_VEL  = 32'd0;
	localparam logic [DATA_W-1:0] RST_GAIN_POS  = 32'd0;
	localparam logic [DATA_W-1:0] RST_DAMPING   = 32'd131072;
	localparam logic [DATA_W-1:0] RST_STIFFNESS = 32'd655360;
	localparam logic [DATA_W-1:0] RST_INV_MASS  = 32'd13107;
	localparam logic [STEP_W-1:0] RST_STEP_SIZE = 24'd16777;
	localparam logic [DATA_W-1:0] RST_INIT_POS  = 32'd6554;
	localparam logic [DATA_W-1:0] RST_INIT_VEL  = 32'd0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_VEL  = 3'd0,
		REG_GAIN_POS  = 3'd1,
		REG_DAMPING   = 3'd2,
		REG_STIFFNESS = 3'd3,
		REG_INV_MASS  = 3'd4,
		REG_STEP_SIZE = 3'd5,
		REG_INIT_POS  = 3'd6,
		REG_INIT_VEL  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_GV   = 3'd1,
		MUL_GP   = 3'd2,
		MUL_DV   = 3'd3,
		MUL_KX   = 3'd4,
		MUL_VDT  = 3'd5,
		MUL_NIM  = 3'd6,
		MUL_ADT  = 3'd7
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE  = 3'd0,
		ACC_LOAD  = 3'd1,
		ACC_ADD   = 3'd2,
		ACC_FORCE = 3'd3,
		ACC_NET   = 3'd4,
		ACC_XNEW  = 3'd5,
		ACC_SAT   = 3'd6
	} acc_op_t;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_GV   = 10'b0000000010,
		ST_GP   = 10'b0000000100,
		ST_DV   = 10'b0000001000,
		ST_KX   = 10'b0000010000,
		ST_VDT  = 10'b0000100000,
		ST_NIM  = 10'b0001000000,
		ST_SACC = 10'b0010000000,
		ST_ADT  = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic     restart;
		logic     commit;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
	} cmd_t;

	typedef struct packed {
		logic emit;
	} stat_t;

	// packed msb first, so position lands in the lowest bits
	typedef struct packed {
		logic [DATA_W-1:0]        step_number;
		logic signed [DATA_W-1:0] force_res;
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] position;
	} res_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] a);
		logic signed [DATA_W-1:0] r;
		if (a > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (a < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = a[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/sdf_ctrl.sv -----
// sequencer of one plant step: schedules the shared multiplier and the accumulator
// depends on sdf_pkg
module sdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          restart,
	input  sdf_pkg::stat_t stat,
	input  logic          out_busy,
	output sdf_pkg::cmd_t  cmd
);
	import sdf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.restart = 1'b0;
		cmd.commit  = 1'b0;
		cmd.mul_sel = MUL_NONE;
		cmd.acc_op  = ACC_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (restart) begin
						cmd.restart = 1'b1;
					end else begin
						state_d = ST_GV;
					end
				end
			end
			ST_GV: begin
				cmd.mul_sel = MUL_GV;
				state_d     = ST_GP;
			end
			ST_GP: begin
				cmd.mul_sel = MUL_GP;
				cmd.acc_op  = ACC_LOAD;
				state_d     = ST_DV;
			end
			ST_DV: begin
				cmd.mul_sel = MUL_DV;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_KX;
			end
			ST_KX: begin
				cmd.mul_sel = MUL_KX;
				cmd.acc_op  = ACC_FORCE;
				state_d     = ST_VDT;
			end
			ST_VDT: begin
				cmd.mul_sel = MUL_VDT;
				cmd.acc_op  = ACC_NET;
				state_d     = ST_NIM;
			end
			ST_NIM: begin
				cmd.mul_sel = MUL_NIM;
				cmd.acc_op  = ACC_XNEW;
				state_d     = ST_SACC;
			end
			ST_SACC: begin
				cmd.acc_op = ACC_SAT;
				state_d    = ST_ADT;
			end
			ST_ADT: begin
				cmd.mul_sel = MUL_ADT;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// keep the velocity product in the register while the step waits
				cmd.mul_sel = MUL_ADT;
				// hold the step until the output register can take the result
				if (!(stat.emit && out_busy)) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/sdf_datapath.sv -----
// config registers, plant state, shared multiplier, accumulator and step counters
// depends on sdf_pkg
module sdf_datapath #(
	parameter int DECIMATION = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdf_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [sdf_pkg::DATA_W-1:0]        cfg_wdata,
	input  sdf_pkg::cmd_t                      cmd,
	output sdf_pkg::stat_t                     stat,
	output sdf_pkg::res_t                      res
);
	import sdf_pkg::*;

	logic signed [DATA_W-1:0] gain_vel_q, gain_pos_q, damping_q, stiffness_q;
	logic signed [DATA_W-1:0] init_pos_q, init_vel_q;
	logic [DATA_W-1:0]        inv_mass_q;
	logic [STEP_W-1:0]        step_size_q;

	logic signed [DATA_W-1:0] pos_q, vel_q;
	logic [CNT_W-1:0]         dec_q;
	logic [DATA_W-1:0]        total_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [DATA_W-1:0] force_q, net_q, xnew_q, accel_q;

	logic signed [PROD_W-1:0] prod_shf, prod_shs, neg_sum, net_sum, xnew_sum, vnew_sum;
	logic signed [DATA_W-1:0] force_sat, vnew;
	logic [CNT_W-1:0]         dec_inc;
	logic [DATA_W-1:0]        total_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_vel_q  <= RST_GAIN_VEL;
			gain_pos_q  <= RST_GAIN_POS;
			damping_q   <= RST_DAMPING;
			stiffness_q <= RST_STIFFNESS;
			inv_mass_q  <= RST_INV_MASS;
			step_size_q <= RST_STEP_SIZE;
			init_pos_q  <= RST_INIT_POS;
			init_vel_q  <= RST_INIT_VEL;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_GAIN_VEL:  gain_vel_q  <= cfg_wdata;
				REG_GAIN_POS:  gain_pos_q  <= cfg_wdata;
				REG_DAMPING:   damping_q   <= cfg_wdata;
				REG_STIFFNESS: stiffness_q <= cfg_wdata;
				REG_INV_MASS:  inv_mass_q  <= cfg_wdata;
				REG_STEP_SIZE: step_size_q <= cfg_wdata[STEP_W-1:0];
				REG_INIT_POS:  init_pos_q  <= cfg_wdata;
				REG_INIT_VEL:  init_vel_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// operand select for the one shared 33x33 multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_GV: begin
				mul_a = {gain_vel_q[DATA_W-1], gain_vel_q};
				mul_b = {vel_q[DATA_W-1], vel_q};
			end
			MUL_GP: begin
				mul_a = {gain_pos_q[DATA_W-1], gain_pos_q};
				mul_b = {pos_q[DATA_W-1], pos_q};
			end
			MUL_DV: begin
				mul_a = {damping_q[DATA_W-1], damping_q};
				mul_b = {vel_q[DATA_W-1], vel_q};
			end
			MUL_KX: begin
				mul_a = {stiffness_q[DATA_W-1], stiffness_q};
				mul_b = {pos_q[DATA_W-1], pos_q};
			end
			MUL_VDT: begin
				mul_a = {vel_q[DATA_W-1], vel_q};
				mul_b = {{(MUL_W-STEP_W){1'b0}}, step_size_q};
			end
			MUL_NIM: begin
				mul_a = {net_q[DATA_W-1], net_q};
				mul_b = {1'b0, inv_mass_q};
			end
			MUL_ADT: begin
				mul_a = {accel_q[DATA_W-1], accel_q};
				mul_b = {{(MUL_W-STEP_W){1'b0}}, step_size_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// arithmetic shifts give floor division
	assign prod_shf  = prod_q >>> FRAC_BITS;
	assign prod_shs  = prod_q >>> STEP_FRAC;
	assign neg_sum   = -acc_q;
	assign force_sat = sat32(neg_sum);
	assign net_sum   = acc_q - prod_shf;
	assign xnew_sum  = {{(PROD_W-DATA_W){pos_q[DATA_W-1]}}, pos_q} + prod_shs;
	assign vnew_sum  = {{(PROD_W-DATA_W){vel_q[DATA_W-1]}}, vel_q} + prod_shs;
	assign vnew      = sat32(vnew_sum);

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_shf;
			ACC_ADD:  acc_q <= acc_q + prod_shf;
			ACC_FORCE: begin
				force_q <= force_sat;
				acc_q   <= {{(PROD_W-DATA_W){force_sat[DATA_W-1]}}, force_sat} - prod_shf;
			end
			ACC_NET:  net_q   <= sat32(net_sum);
			ACC_XNEW: xnew_q  <= sat32(xnew_sum);
			ACC_SAT:  accel_q <= sat32(prod_shf);
			default: begin
			end
		endcase
	end

	assign dec_inc   = dec_q + CNT_W'(1);
	assign total_inc = total_q + DATA_W'(1);
	assign stat.emit = (dec_inc == CNT_W'(DECIMATION));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= RST_INIT_POS;
			vel_q   <= RST_INIT_VEL;
			dec_q   <= '0;
			total_q <= '0;
		end else if (cmd.restart) begin
			pos_q   <= init_pos_q;
			vel_q   <= init_vel_q;
			dec_q   <= '0;
			total_q <= '0;
		end else if (cmd.commit) begin
			pos_q   <= xnew_q;
			vel_q   <= vnew;
			dec_q   <= stat.emit ? '0 : dec_inc;
			total_q <= total_inc;
		end
	end

	assign res.position    = xnew_q;
	assign res.velocity    = vnew;
	assign res.force_res   = force_q;
	assign res.step_number = total_inc;

endmodule

// ----- sv/sdf_out_stage.sv -----
// result register on the master stream side
// depends on sdf_pkg
module sdf_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sdf_pkg::res_t  res,
	output logic          busy,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata
);
	import sdf_pkg::*;

	logic valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign busy     = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = res_q;

endmodule

// ----- sv/spring_damper_feedback_sim_core.sv -----
// top level of the spring-damper plant with state feedback
// depends on sdf_pkg, sdf_ctrl, sdf_datapath, sdf_out_stage
//
// s_axis carries one tick per transfer; s_tdata[0] is restart. A restart tick
// reloads init_pos/init_vel, clears the step counters and yields no result.
// Any other tick advances the plant one forward-Euler step (accept plus nine
// sequencer steps); no new tick is taken until that step is done. That is due
// to the single 33x33 multiplier, which computes the seven chained products
// of a step one after another, each product registered before the
// accumulator uses it.
// Every DECIMATION-th step loads a result into the output register, visible
// on m_axis the cycle after the step ends. While that result waits, the
// next tick is still accepted and computed; only the end of a step that has
// a result to deliver waits for the receiver to take the previous one.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata) to be used
// while the block is idle. Reset puts all config registers at their defaults,
// the plant at the default initial conditions and empties the output register.
module spring_damper_feedback_sim_core #(
	parameter int DECIMATION = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [0] restart, [7:1] zero
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata    // position, velocity, force_res, step_number
);
	import sdf_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	logic  out_busy;

	sdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.restart  (s_tdata[0]),
		.stat     (stat),
		.out_busy (out_busy),
		.cmd      (cmd)
	);

	sdf_datapath #(
		.DECIMATION (DECIMATION),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	sdf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.commit && stat.emit),
		.res      (res),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
